>>> design/cbu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_pkg
// Types, constants and row helpers for the 2x chroma block upsampler.
// ----------------------------------------------------------------------------
package cbu_pkg;

    localparam int unsigned NumCols  = 8;
    localparam int unsigned WideCols = 2 * NumCols;

    localparam logic [2:0] FirstInRow = 3'd0;
    localparam logic [2:0] LastInRow  = 3'd7;
    localparam logic [3:0] MidRow     = 4'd14;
    localparam logic [3:0] LastRow    = 4'd15;

    // index of the final result for each kind of input row
    localparam logic [2:0] IdxEndFirst = 3'd1;
    localparam logic [2:0] IdxEndMid   = 3'd3;
    localparam logic [2:0] IdxEndLast  = 3'd5;

    typedef logic [7:0]                  t_sample;
    typedef t_sample [NumCols-1:0]       t_half_row;
    typedef t_sample [WideCols-1:0]      t_wide_row;

    typedef struct packed {
        t_sample sample_0;
        t_sample sample_1;
        t_sample sample_2;
        t_sample sample_3;
        t_sample sample_4;
        t_sample sample_5;
        t_sample sample_6;
        t_sample sample_7;
        logic    component;
    } t_in_item;

    typedef struct packed {
        t_sample    pix_0;
        t_sample    pix_1;
        t_sample    pix_2;
        t_sample    pix_3;
        t_sample    pix_4;
        t_sample    pix_5;
        t_sample    pix_6;
        t_sample    pix_7;
        logic [3:0] out_row;
        logic       half;
        logic       plane;
        logic       last;
    } t_out_item;

    function automatic t_sample mean2(input t_sample a, input t_sample b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

    // 8 samples -> 16 pixels; odd columns average right neighbor, column 15 repeats 7
    function automatic t_wide_row widen(input t_in_item it);
        t_half_row s;
        t_wide_row w;
        s[0] = it.sample_0;
        s[1] = it.sample_1;
        s[2] = it.sample_2;
        s[3] = it.sample_3;
        s[4] = it.sample_4;
        s[5] = it.sample_5;
        s[6] = it.sample_6;
        s[7] = it.sample_7;
        for (int c = 0; c < NumCols - 1; c++) begin
            w[2*c]   = s[c];
            w[2*c+1] = mean2(s[c], s[c+1]);
        end
        w[WideCols-2] = s[NumCols-1];
        w[WideCols-1] = s[NumCols-1];
        return w;
    endfunction

    function automatic logic [2:0] last_index(input logic [2:0] in_row);
        if (in_row == FirstInRow) begin
            return IdxEndFirst;
        end else if (in_row == LastInRow) begin
            return IdxEndLast;
        end else begin
            return IdxEndMid;
        end
    endfunction

endpackage

>>> design/cbu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_if
// Valid/ready channels for input rows and output half rows.
// ----------------------------------------------------------------------------
interface cbu_in_if;
    logic             valid;
    logic             ready;
    cbu_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbu_out_if;
    logic              valid;
    logic              ready;
    cbu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/chroma_block_upsample_2x_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_block_upsample_2x_unit
// 8x8 chroma block in, one row per transaction; 16x16 block out as half rows.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              per transaction
//  i_row     in   sample_0..7, component               one 8-sample row
//  o_pix     out  pix_0..7, out_row, half, plane, last one 8-pixel half row
//
//  An input row is widened and blended with the stored previous row in the
//  cycle it is accepted; its results then leave one per cycle from the output
//  register: 2 for row 0, 4 for rows 1..6, 6 for row 7 (32 results per block).
//  The next row is taken in the cycle its predecessor's last result moves to
//  the output register. Reset clears the row counter and both valid flags.
//  A stall on o_pix holds the output register and then backs up into i_row.
// ----------------------------------------------------------------------------
module chroma_block_upsample_2x_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cbu_in_if.sink          i_row,
    cbu_out_if.source       o_pix
);

    cbu_pkg::t_wide_row  w_cur, w_mid;
    cbu_pkg::t_wide_row  r_prev, r_cur, r_mid;
    cbu_pkg::t_wide_row  w_src;
    cbu_pkg::t_half_row  w_half_pix;
    cbu_pkg::t_out_item  w_result;
    cbu_pkg::t_out_item  r_o_item;

    logic [2:0] r_row_cnt, n_row_cnt;
    logic       r_w_valid, n_w_valid;
    logic [2:0] r_w_row;
    logic       r_w_plane;
    logic [2:0] r_w_idx, n_w_idx;
    logic       r_o_valid, n_o_valid;

    logic       w_accept, w_load, w_w_done;
    logic [2:0] w_last_idx;
    logic       w_use_mid;
    logic [3:0] w_even_row;

    always_comb begin
        w_cur = cbu_pkg::widen(i_row.data);
        for (int i = 0; i < cbu_pkg::WideCols; i++) begin
            w_mid[i] = cbu_pkg::mean2(r_prev[i], w_cur[i]);
        end
    end

    assign w_last_idx  = cbu_pkg::last_index(r_w_row);
    assign w_load      = r_w_valid && (!r_o_valid || o_pix.ready);
    assign w_w_done    = w_load && (r_w_idx == w_last_idx);
    assign i_row.ready = !r_w_valid || w_w_done;
    assign w_accept    = i_row.valid && i_row.ready;

    // first output row of a non-first input row is the blended one
    assign w_use_mid  = (r_w_row != cbu_pkg::FirstInRow) && (r_w_idx[2:1] == 2'd0);
    assign w_src      = w_use_mid ? r_mid : r_cur;
    assign w_even_row = {r_w_row, 1'b0};

    always_comb begin
        for (int j = 0; j < cbu_pkg::NumCols; j++) begin
            w_half_pix[j] = w_src[{r_w_idx[0], j[2:0]}];
        end
        w_result.pix_0 = w_half_pix[0];
        w_result.pix_1 = w_half_pix[1];
        w_result.pix_2 = w_half_pix[2];
        w_result.pix_3 = w_half_pix[3];
        w_result.pix_4 = w_half_pix[4];
        w_result.pix_5 = w_half_pix[5];
        w_result.pix_6 = w_half_pix[6];
        w_result.pix_7 = w_half_pix[7];
        if (r_w_row == cbu_pkg::FirstInRow) begin
            w_result.out_row = 4'd0;
        end else if (r_w_idx[2:1] == 2'd0) begin
            w_result.out_row = w_even_row - 4'd1;
        end else if (r_w_idx[2:1] == 2'd1) begin
            w_result.out_row = w_even_row;
        end else begin
            w_result.out_row = cbu_pkg::LastRow;
        end
        w_result.half  = r_w_idx[0];
        w_result.plane = r_w_plane;
        w_result.last  = (r_w_idx == w_last_idx);
    end

    always_comb begin
        n_row_cnt = r_row_cnt;
        n_w_valid = r_w_valid;
        n_w_idx   = r_w_idx;
        n_o_valid = r_o_valid;
        if (o_pix.ready) begin
            n_o_valid = 1'b0;
        end
        if (w_load) begin
            n_o_valid = 1'b1;
            n_w_idx   = r_w_idx + 3'd1;
        end
        if (w_w_done) begin
            n_w_valid = 1'b0;
        end
        if (w_accept) begin
            n_w_valid = 1'b1;
            n_w_idx   = 3'd0;
            n_row_cnt = r_row_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_w_valid <= 1'b0;
            r_w_idx   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_row_cnt <= n_row_cnt;
            r_w_valid <= n_w_valid;
            r_w_idx   <= n_w_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev    <= w_cur;
            r_cur     <= w_cur;
            r_mid     <= w_mid;
            r_w_row   <= r_row_cnt;
            r_w_plane <= i_row.data.component;
        end
        if (w_load) begin
            r_o_item <= w_result;
        end
    end

    assign o_pix.valid = r_o_valid;
    assign o_pix.data  = r_o_item;

endmodule

>>> design/cbu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_chk
// Port-level checks for the chroma upsampler, bound to the top level.
// ----------------------------------------------------------------------------
module cbu_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cbu_pkg::t_out_item i_out_data
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output changed while stalled");

    // every input row yields at least two results; the first passes the working row registers, then the output register
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> ##1 i_out_valid)
        else $error("accepted row produced no result");

    // last only closes an output row
    a_last_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.last |-> i_out_data.half)
        else $error("last flagged on left half");

    // a row ends on an even output row or on the repeated bottom row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.last |->
            !i_out_data.out_row[0] || i_out_data.out_row == cbu_pkg::LastRow)
        else $error("last flagged on an interpolated row");

endmodule

bind chroma_block_upsample_2x_unit cbu_chk u_cbu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_row.valid),
    .i_in_ready  (i_row.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);

>>> dv/chroma_block_upsample_2x_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_block_upsample_2x_unit_tb
// Sends 8x8 chroma blocks row by row through the 2x upsampler and checks
// every 8-pixel half row against an in-bench prediction. The stimulus is
// directed extreme blocks followed by random blocks, with bursty input and
// stalls on the output.
// ----------------------------------------------------------------------------
module chroma_block_upsample_2x_unit_tb;

    localparam int unsigned RandBlocks = 30;
    localparam int unsigned SettleCyc  = 40;

    typedef struct {
        cbu_pkg::t_in_item row;
        bit                drain_first;  // hold off until all pending half rows are out
    } t_pending_row;

    logic clk;
    logic rst_n;

    cbu_in_if  row_ch ();
    cbu_out_if pix_ch ();

    chroma_block_upsample_2x_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_row   (row_ch),
        .o_pix   (pix_ch)
    );

    t_pending_row       pending_rows[$];
    cbu_pkg::t_out_item expected_half_rows[$];

    // predictor state
    cbu_pkg::t_wide_row prev_wide;
    logic [2:0]         in_row_idx;

    int unsigned  err_count;
    int unsigned  rows_accepted;
    int unsigned  halves_checked;
    int unsigned  drain_pauses;
    bit           row_taken;

    // sender burst / gap and receiver stall pattern
    int unsigned  burst_left;
    int unsigned  gap_left;
    int unsigned  rx_mode;
    int unsigned  rx_mode_left;
    int unsigned  rx_stall_left;

    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        row_ch.valid      = 1'b0;
        row_ch.data       = '0;
        pix_ch.ready      = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic cbu_pkg::t_sample avg_floor(input cbu_pkg::t_sample a,
                                                   input cbu_pkg::t_sample b);
        logic [8:0] s;
        s = 9'(a) + 9'(b);
        return s[8:1];
    endfunction

    function automatic cbu_pkg::t_wide_row stretch_row(input cbu_pkg::t_in_item it);
        cbu_pkg::t_sample   s[8];
        cbu_pkg::t_wide_row w;
        int                 c;
        s = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3,
              it.sample_4, it.sample_5, it.sample_6, it.sample_7};
        for (int j = 0; j < 16; j++) begin
            c = j / 2;
            if (j % 2 == 0 || c == 7) begin
                w[j] = s[c];
            end else begin
                w[j] = avg_floor(s[c], s[c+1]);
            end
        end
        return w;
    endfunction

    task automatic queue_out_row(input cbu_pkg::t_wide_row w, input logic [3:0] orow,
                                 input logic plane, input bit ends_row);
        cbu_pkg::t_out_item o;
        for (int h = 0; h < 2; h++) begin
            o.pix_0   = w[h*8 + 0];
            o.pix_1   = w[h*8 + 1];
            o.pix_2   = w[h*8 + 2];
            o.pix_3   = w[h*8 + 3];
            o.pix_4   = w[h*8 + 4];
            o.pix_5   = w[h*8 + 5];
            o.pix_6   = w[h*8 + 6];
            o.pix_7   = w[h*8 + 7];
            o.out_row = orow;
            o.half    = 1'(h);
            o.plane   = plane;
            o.last    = ends_row && (h == 1);
            expected_half_rows.push_back(o);
        end
    endtask

    task automatic predict_upsampled_rows(input cbu_pkg::t_in_item it);
        cbu_pkg::t_wide_row cur;
        cbu_pkg::t_wide_row blend;
        cur = stretch_row(it);
        if (in_row_idx == cbu_pkg::FirstInRow) begin
            queue_out_row(cur, 4'd0, it.component, 1'b1);
        end else begin
            for (int j = 0; j < 16; j++) begin
                blend[j] = avg_floor(prev_wide[j], cur[j]);
            end
            queue_out_row(blend, {in_row_idx, 1'b0} - 4'd1, it.component, 1'b0);
            if (in_row_idx == cbu_pkg::LastInRow) begin
                queue_out_row(cur, cbu_pkg::MidRow, it.component, 1'b0);
                queue_out_row(cur, cbu_pkg::LastRow, it.component, 1'b1);
            end else begin
                queue_out_row(cur, {in_row_idx, 1'b0}, it.component, 1'b1);
            end
        end
        prev_wide  = cur;
        in_row_idx = in_row_idx + 3'd1;
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic cbu_pkg::t_in_item make_row(input cbu_pkg::t_sample v[8],
                                                   input logic comp);
        cbu_pkg::t_in_item it;
        it.sample_0  = v[0];
        it.sample_1  = v[1];
        it.sample_2  = v[2];
        it.sample_3  = v[3];
        it.sample_4  = v[4];
        it.sample_5  = v[5];
        it.sample_6  = v[6];
        it.sample_7  = v[7];
        it.component = comp;
        return it;
    endfunction

    function automatic cbu_pkg::t_sample pick_sample(input int unsigned style,
                                                     input cbu_pkg::t_sample base);
        case (style)
            0: return cbu_pkg::t_sample'(int'(base) + $urandom_range(0, 6) - 3);
            1: return cbu_pkg::t_sample'($urandom);
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 8'd0;
                    1: return 8'd255;
                    2: return cbu_pkg::t_sample'($urandom_range(250, 255));
                    default: return cbu_pkg::t_sample'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic add_row(input cbu_pkg::t_in_item it, input bit drain);
        t_pending_row p;
        p.row         = it;
        p.drain_first = drain;
        pending_rows.push_back(p);
    endtask

    function automatic cbu_pkg::t_sample pix_at(input cbu_pkg::t_out_item o, input int k);
        logic [$bits(cbu_pkg::t_out_item)-1:0] v;
        v = o;
        return v[$bits(cbu_pkg::t_out_item) - 1 - 8*k -: 8];
    endfunction

    // ------------------------------------------------------------------------
    // input side: driver at the falling edge, acceptance at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        row_taken <= row_ch.valid && row_ch.ready;
        if (rst_n && row_ch.valid && row_ch.ready) begin
            predict_upsampled_rows(row_ch.data);
            rows_accepted <= rows_accepted + 1;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            row_ch.valid <= 1'b0;
            burst_left   <= $urandom_range(1, 12);
            gap_left     <= 0;
        end else if (row_ch.valid && !row_taken) begin
            // transaction still pending, hold
        end else if (gap_left != 0) begin
            row_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end else if (pending_rows.size() == 0) begin
            row_ch.valid <= 1'b0;
        end else if (pending_rows[0].drain_first && expected_half_rows.size() != 0) begin
            row_ch.valid <= 1'b0;
        end else begin
            if (pending_rows[0].drain_first) begin
                drain_pauses <= drain_pauses + 1;
            end
            row_ch.data  <= pending_rows[0].row;
            row_ch.valid <= 1'b1;
            void'(pending_rows.pop_front());
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                // about a third of the bursts run straight into the next
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output side: stall pattern and checker
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            pix_ch.ready  <= 1'b0;
            rx_mode       <= 0;
            rx_mode_left  <= 0;
            rx_stall_left <= 0;
        end else if (rx_mode_left == 0) begin
            rx_mode       <= $urandom_range(0, 2);
            rx_mode_left  <= $urandom_range(16, 64);
            rx_stall_left <= 0;
            pix_ch.ready  <= 1'b1;
        end else begin
            rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0: pix_ch.ready <= 1'b1;
                1: pix_ch.ready <= ($urandom_range(0, 9) < 7);
                default: begin
                    // long stall runs separated by single open cycles
                    if (rx_stall_left != 0) begin
                        pix_ch.ready  <= 1'b0;
                        rx_stall_left <= rx_stall_left - 1;
                    end else begin
                        pix_ch.ready  <= 1'b1;
                        rx_stall_left <= $urandom_range(1, 6);
                    end
                end
            endcase
        end
    end

    always @(posedge clk) begin
        cbu_pkg::t_out_item want;
        cbu_pkg::t_out_item got;
        if (rst_n && pix_ch.valid && pix_ch.ready) begin
            got = pix_ch.data;
            if (expected_half_rows.size() == 0) begin
                $display("%0t: unexpected half row: got %p", $time, got);
                err_count = err_count + 1;
            end else begin
                want = expected_half_rows.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (pix_at(got, k) !== pix_at(want, k)) begin
                        $display("%0t: half row %0d pix_%0d expected %0d got %0d",
                                 $time, halves_checked, k, pix_at(want, k), pix_at(got, k));
                        err_count = err_count + 1;
                    end
                end
                if (got.out_row !== want.out_row) begin
                    $display("%0t: half row %0d out_row expected %0d got %0d",
                             $time, halves_checked, want.out_row, got.out_row);
                    err_count = err_count + 1;
                end
                if (got.half !== want.half) begin
                    $display("%0t: half row %0d half expected %0d got %0d",
                             $time, halves_checked, want.half, got.half);
                    err_count = err_count + 1;
                end
                if (got.plane !== want.plane) begin
                    $display("%0t: half row %0d plane expected %0d got %0d",
                             $time, halves_checked, want.plane, got.plane);
                    err_count = err_count + 1;
                end
                if (got.last !== want.last) begin
                    $display("%0t: half row %0d last expected %0d got %0d",
                             $time, halves_checked, want.last, got.last);
                    err_count = err_count + 1;
                end
            end
            halves_checked = halves_checked + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        cbu_pkg::t_sample v[8];
        cbu_pkg::t_sample base;
        int unsigned      style;
        logic             comp;
        bit               comp_per_row;

        err_count      = 0;
        rows_accepted  = 0;
        halves_checked = 0;
        drain_pauses   = 0;
        in_row_idx     = cbu_pkg::FirstInRow;
        prev_wide      = '0;

        // checkerboard of 0/255: largest horizontal and vertical swings
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                v[c] = ((r + c) % 2 == 0) ? 8'd0 : 8'd255;
            end
            add_row(make_row(v, 1'b0), 1'b0);
        end
        // saturated block on Cr: sums reach their maximum
        for (int r = 0; r < 8; r++) begin
            v = '{default: 8'd255};
            add_row(make_row(v, 1'b1), 1'b0);
        end
        // plane tag toggling inside one block, walking single-bit samples
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                v[c] = cbu_pkg::t_sample'(1 << ((r + c) % 8));
            end
            add_row(make_row(v, 1'(r % 2)), r == 4);
        end

        for (int b = 0; b < RandBlocks; b++) begin
            style        = $urandom_range(0, 3);
            base         = cbu_pkg::t_sample'($urandom);
            comp         = 1'($urandom);
            comp_per_row = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < 8; r++) begin
                for (int c = 0; c < 8; c++) begin
                    v[c] = pick_sample(style, base);
                end
                add_row(make_row(v, comp_per_row ? 1'($urandom) : comp),
                        (b == 0 && r == 0) || (r == 0 && $urandom_range(0, 5) == 0)
                        || $urandom_range(0, 39) == 0);
            end
        end

        @(posedge rst_n);
        while (pending_rows.size() != 0 || row_ch.valid === 1'b1
               || expected_half_rows.size() != 0) begin
            @(posedge clk);
        end
        repeat (SettleCyc) @(posedge clk);

        if (expected_half_rows.size() != 0) begin
            $display("%0t: %0d half rows never arrived", $time, expected_half_rows.size());
            err_count = err_count + 1;
        end
        $display("Run covered %0d input rows (%0d blocks) and %0d half rows checked,",
                 rows_accepted, rows_accepted / 8, halves_checked);
        $display("including plane changes mid-block and %0d drain pauses.", drain_pauses);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("%0t: timeout", $time);
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
design/cbu_pkg.sv
design/cbu_if.sv
design/chroma_block_upsample_2x_unit.sv
design/cbu_chk.sv
dv/chroma_block_upsample_2x_unit_tb.sv
